/* rtl/fpsc_pkg.sv */
// Shared types, constants and saturation and sign helpers for the PI speed controller.
`default_nettype none
package fpsc_pkg;

    localparam int unsigned WideW = 64;
    localparam int unsigned SatW  = 56;

    localparam logic signed [30:0] DriveMax = 31'sh3FFFFFFF;
    localparam logic signed [30:0] DriveMin = 31'sh40000000;

    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [WideW-1:0] a;
        logic [31:0]      b;
        logic [6:0]       steps;
    } t_md_req;

    typedef struct packed {
        logic             done;
        logic [WideW-1:0] result;
    } t_md_rsp;

    function automatic logic signed [30:0] sat_q30(input logic signed [SatW-1:0] x);
        logic signed [30:0] r;
        if (x > SatW'(signed'(DriveMax))) begin
            r = DriveMax;
        end else if (x < SatW'(signed'(DriveMin))) begin
            r = DriveMin;
        end else begin
            r = x[30:0];
        end
        return r;
    endfunction

    function automatic logic signed [SatW-1:0] apply_sign(input logic neg,
                                                          input logic [WideW-1:0] m);
        logic signed [SatW-1:0] v;
        v = signed'(m[SatW-1:0]);
        return neg ? -v : v;
    endfunction

endpackage
`default_nettype wire

/* rtl/fpsc_muldiv.sv */
// Shared bit-serial unit: shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module fpsc_muldiv (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fpsc_pkg::t_md_req   i_req,
    output fpsc_pkg::t_md_rsp   o_rsp
);
    import fpsc_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_isdiv, n_isdiv;
    logic [6:0]       r_cnt, n_cnt;
    logic [WideW-1:0] r_acc, n_acc;
    logic [WideW-1:0] r_op, n_op;
    logic [31:0]      r_mp, n_mp;
    logic [9:0]       r_rem, n_rem;
    logic [9:0]       r_dvs, n_dvs;
    logic [10:0]      trial;
    logic             ge;

    always_comb begin
        trial   = {r_rem, r_acc[WideW-1]};
        ge      = trial >= {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_isdiv = r_isdiv;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_op    = r_op;
        n_mp    = r_mp;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_isdiv = i_req.is_div;
            n_cnt   = i_req.steps;
            n_acc   = i_req.is_div ? i_req.a : '0;
            n_op    = i_req.a;
            n_mp    = i_req.b;
            n_rem   = '0;
            n_dvs   = i_req.b[9:0];
        end else if (r_busy) begin
            if (r_isdiv) begin
                n_rem = ge ? 10'(trial - {1'b0, r_dvs}) : trial[9:0];
                n_acc = {r_acc[WideW-2:0], ge};
            end else begin
                if (r_mp[0]) begin
                    n_acc = r_acc + r_op;
                end
                n_op = {r_op[WideW-2:0], 1'b0};
                n_mp = {1'b0, r_mp[31:1]};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_isdiv <= n_isdiv;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_op    <= n_op;
        r_mp    <= n_mp;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule
`default_nettype wire

/* rtl/fixed_point_pi_speed_controller.sv */
// Top level of the PI speed controller: stream ports, configuration and the update sequencer.
//
//  Channel    | Direction | Contents
//  s_axis     | in        | tdata: reference_rpm, measured_rpm, time_ms; tuser: opcode
//  m_axis     | out       | tdata: drive (31 bits, zero padded to 32)
//  cfg        | in        | write enable, register index, 31-bit data
//
// Restart, first and zero-time updates skip the bit-serial unit and go straight to the output
// state. A full update runs the bit-serial unit: up to 22 steps for the error scaling, 17 and
// 16 for the feedforward and proportional products, and, inside the integration window,
// 16 + 32 + 64 for the integrator step, before the drive is formed and registered.
// Reset is synchronous and active low. A new transaction is taken only when the sequencer
// is idle; a finished drive waits in the output register while the next one is computed.
`default_nettype none
module fixed_point_pi_speed_controller (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // reference_rpm[15:0], measured_rpm[31:16], time_ms[63:32]
    input  wire  [0:0]  s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // drive[30:0], zero [31]
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [30:0] i_cfg_data
);
    import fpsc_pkg::*;

    localparam logic [2:0] RegPropGain   = 3'd0;
    localparam logic [2:0] RegIntGain    = 3'd1;
    localparam logic [2:0] RegFfGain     = 3'd2;
    localparam logic [2:0] RegDeadband   = 3'd3;
    localparam logic [2:0] RegWindow     = 3'd4;
    localparam logic [2:0] RegIntLimit   = 3'd5;

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StDivE = 4'd1;
    localparam logic [3:0] StMff  = 4'd2;
    localparam logic [3:0] StMpt  = 4'd3;
    localparam logic [3:0] StMi1  = 4'd4;
    localparam logic [3:0] StMi2  = 4'd5;
    localparam logic [3:0] StDivI = 4'd6;
    localparam logic [3:0] StFin  = 4'd7;
    localparam logic [3:0] StOut  = 4'd8;

    localparam int unsigned OpW = 1;
    localparam logic [OpW-1:0] OpRestart = 1'b1;

    logic [14:0]        r_pg, r_ig;
    logic signed [30:0] r_fg;
    logic [15:0]        r_db, r_iw;
    logic [29:0]        r_lim;

    logic [3:0]         r_state;
    logic signed [30:0] r_acc;
    logic [31:0]        r_prev;
    logic               r_first;
    logic signed [15:0] r_ref;
    logic [31:0]        r_dt;
    logic               r_eneg, r_win;
    logic [15:0]        r_eqmag;
    logic signed [30:0] r_ff, r_pt, r_res;
    logic [53:0]        r_dimag;
    logic               r_ov;
    logic [30:0]        r_od;
    t_md_req            r_req;
    t_md_rsp            rsp;

    logic               in_fire;
    logic signed [15:0] in_ref, in_meas;
    logic [31:0]        in_now, in_dt;
    logic signed [16:0] err;
    logic [16:0]        emag, emag_eff;
    logic               dead;
    logic [16:0]        refmag;
    logic [30:0]        fgmag;
    logic signed [SatW-1:0] di, isum, sum, dsum;
    logic signed [30:0] cand_sat, cand, new_acc;
    logic signed [30:0] lim_s;
    logic               eq_pos, eq_neg, commit;

    fpsc_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (rsp)
    );

    assign s_axis_tready = (r_state == StIdle);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_ref   = signed'(s_axis_tdata[15:0]);
    assign in_meas  = signed'(s_axis_tdata[31:16]);
    assign in_now   = s_axis_tdata[63:32];
    assign in_dt    = in_now - r_prev;
    assign err      = 17'(in_ref) - 17'(in_meas);
    assign emag     = err[16] ? 17'(-err) : 17'(err);
    assign dead     = emag <= {1'b0, r_db};
    assign emag_eff = dead ? 17'd0 : emag;
    assign refmag   = r_ref[15] ? 17'(-17'(r_ref)) : 17'(r_ref);
    assign fgmag    = r_fg[30] ? 31'(-r_fg) : 31'(r_fg);

    assign di       = apply_sign(r_eneg, {10'd0, r_dimag});
    assign isum     = SatW'(r_acc) + di;
    assign lim_s    = signed'({1'b0, r_lim});
    always_comb begin
        cand_sat = sat_q30(isum);
        if (cand_sat > lim_s) begin
            cand_sat = lim_s;
        end else if (cand_sat < -lim_s) begin
            cand_sat = -lim_s;
        end
    end
    assign cand    = r_win ? cand_sat : r_acc;
    assign sum     = SatW'(r_ff) + SatW'(r_pt) + SatW'(cand);
    assign eq_pos  = !r_eneg && (r_eqmag != 16'd0);
    assign eq_neg  = r_eneg && (r_eqmag != 16'd0);
    assign commit  = !((sum > SatW'(DriveMax) && eq_pos) || (sum < SatW'(DriveMin) && eq_neg));
    assign new_acc = commit ? cand : r_acc;
    assign dsum    = SatW'(r_ff) + SatW'(r_pt) + SatW'(new_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg    <= 15'd1300;
            r_ig    <= 15'd4000;
            r_fg    <= 31'sd99000;
            r_db    <= 16'd10;
            r_iw    <= 16'd200;
            r_lim   <= 30'd300000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                RegPropGain: r_pg  <= i_cfg_data[14:0];
                RegIntGain:  r_ig  <= i_cfg_data[14:0];
                RegFfGain:   r_fg  <= signed'(i_cfg_data);
                RegDeadband: r_db  <= i_cfg_data[15:0];
                RegWindow:   r_iw  <= i_cfg_data[15:0];
                RegIntLimit: r_lim <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_acc   <= '0;
            r_prev  <= '0;
            r_first <= 1'b1;
            r_ov    <= 1'b0;
            r_req   <= '0;
        end else begin
            if (r_ov && m_axis_tready && (r_state != StOut)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                StIdle: begin
                    if (in_fire) begin
                        r_res <= '0;
                        r_ref <= in_ref;
                        if (s_axis_tuser == OpRestart) begin
                            r_acc   <= '0;
                            r_prev  <= '0;
                            r_first <= 1'b1;
                            r_state <= StOut;
                        end else if (r_first) begin
                            r_first <= 1'b0;
                            r_prev  <= in_now;
                            r_acc   <= '0;
                            r_state <= StOut;
                        end else begin
                            r_prev <= in_now;
                            r_dt   <= in_dt;
                            r_eneg <= err[16] && !dead;
                            r_win  <= emag_eff <= {1'b0, r_iw};
                            if (in_dt == 32'd0) begin
                                r_state <= StOut;
                            end else if (emag_eff >= 17'd4000) begin
                                r_eqmag <= (err[16] && !dead) ? 16'd32768 : 16'd32767;
                                r_state <= StMff;
                                r_req   <= '{1'b1, 1'b0,
                                            64'(fgmag),
                                            32'(in_ref[15] ? 17'(-17'(in_ref)) : 17'(in_ref)),
                                            7'd17};
                            end else begin
                                r_state <= StDivE;
                                r_req   <= '{1'b1, 1'b1, {emag_eff[11:0], 52'd0},
                                            32'd125, 7'd22};
                            end
                        end
                    end
                end
                StDivE: begin
                    if (rsp.done) begin
                        r_eqmag <= {1'b0, rsp.result[14:0]};
                        r_state <= StMff;
                        r_req   <= '{1'b1, 1'b0, 64'(fgmag), 32'(refmag), 7'd17};
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StMff: begin
                    if (rsp.done) begin
                        r_ff    <= sat_q30(apply_sign(r_fg[30] ^ r_ref[15], rsp.result));
                        r_state <= StMpt;
                        r_req   <= '{1'b1, 1'b0, 64'(r_pg), 32'(r_eqmag), 7'd16};
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StMpt: begin
                    if (rsp.done) begin
                        r_pt <= sat_q30(apply_sign(r_eneg, rsp.result));
                        if (r_win) begin
                            r_state <= StMi1;
                            r_req   <= '{1'b1, 1'b0, 64'(r_ig), 32'(r_eqmag), 7'd16};
                        end else begin
                            r_dimag <= '0;
                            r_state <= StFin;
                        end
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StMi1: begin
                    if (rsp.done) begin
                        r_state <= StMi2;
                        r_req   <= '{1'b1, 1'b0, rsp.result, r_dt, 7'd32};
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StMi2: begin
                    if (rsp.done) begin
                        r_state <= StDivI;
                        r_req   <= '{1'b1, 1'b1, rsp.result, 32'd1000, 7'd64};
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StDivI: begin
                    if (rsp.done) begin
                        r_dimag <= rsp.result[53:0];
                        r_state <= StFin;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                StFin: begin
                    r_acc   <= new_acc;
                    r_res   <= sat_q30(dsum);
                    r_state <= StOut;
                end
                StOut: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_od    <= r_res;
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_od};

endmodule
`default_nettype wire
